### rtl/tspe_pkg.sv
// Shared types, constants and helpers for the ternary synapse plasticity engine.
package tspe_pkg;

    localparam int MAX_PRE   = 64;
    localparam int MAX_POST  = 64;
    localparam int ACC_WIDTH = 24;
    localparam int ROW_W     = $clog2(MAX_PRE);
    localparam int COL_W     = $clog2(MAX_POST);
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int CELLS     = MAX_PRE * MAX_POST;
    localparam int CNT_W     = 7;
    localparam int CHG_W     = 13;
    localparam int QDEPTH    = 2;

    typedef enum logic [2:0] {
        OP_UPDATE = 3'd0,
        OP_DECAY  = 3'd1,
        OP_DISC   = 3'd2,
        OP_LOAD   = 3'd3,
        OP_READ   = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        CFG_LTP  = 2'd0,
        CFG_LTD  = 2'd1,
        CFG_PRE  = 2'd2,
        CFG_POST = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_CHANGE = 2'd1,
        ST_RANGE  = 2'd2
    } t_status;

    // Classified command handed from front to back
    typedef struct packed {
        t_op                kind;
        logic               inr;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic signed [15:0] delta;
        logic [16:0]        factor;
        logic signed [1:0]  weight;
    } t_cmd;

    typedef enum logic [2:0] {
        BS_IDLE  = 3'd0,
        BS_READ  = 3'd1,
        BS_EXEC  = 3'd2,
        BS_SWEEP = 3'd3,
        BS_FETCH = 3'd4,
        BS_DONE  = 3'd5
    } t_bstate;

    // Threshold rules on a weight
    function automatic logic signed [1:0] rule_next(
        input logic signed [1:0]           cur,
        input logic signed [ACC_WIDTH-1:0] acc,
        input logic signed [ACC_WIDTH-1:0] ltp,
        input logic signed [ACC_WIDTH-1:0] ltd
    );
        logic signed [1:0] nw;
        nw = cur;
        if (cur == 2'sd0) begin
            if (acc >= ltp)      nw = 2'sd1;
            else if (acc <= ltd) nw = -2'sd1;
        end else if (cur == 2'sd1) begin
            if (acc <= ltd)      nw = 2'sd0;
        end else begin
            if (acc >= ltp)      nw = 2'sd0;
        end
        return nw;
    endfunction

endpackage

### rtl/tspe_front.sv
// Front end: accepts items, clamps the decay factor and weight value, range checks and queues commands.
module tspe_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic [2:0]            i_operation,
    input  logic [5:0]            i_pre_index,
    input  logic [5:0]            i_post_index,
    input  logic signed [15:0]    i_delta,
    input  logic [16:0]           i_decay_factor,
    input  logic signed [1:0]     i_weight_value,
    input  logic [tspe_pkg::CNT_W-1:0] i_rows,
    input  logic [tspe_pkg::CNT_W-1:0] i_cols,
    output logic                  o_cmd_valid,
    output tspe_pkg::t_cmd        o_cmd,
    input  logic                  i_cmd_take
);
    import tspe_pkg::*;

    t_cmd             r_q [QDEPTH];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    t_cmd             n_cmd;
    logic             push_ok, take_ok;

    // Classify the incoming item
    always_comb begin
        n_cmd.inr    = ({1'b0, i_pre_index} < i_rows) && ({1'b0, i_post_index} < i_cols);
        n_cmd.row    = i_pre_index[ROW_W-1:0];
        n_cmd.col    = i_post_index[COL_W-1:0];
        n_cmd.delta  = i_delta;
        n_cmd.factor = (i_decay_factor > 17'd65536) ? 17'd65536 : i_decay_factor;
        n_cmd.weight = (i_weight_value == -2'sd2) ? -2'sd1 : i_weight_value;
        unique case (i_operation)
            3'd0:    n_cmd.kind = OP_UPDATE;
            3'd1:    n_cmd.kind = OP_DECAY;
            3'd2:    n_cmd.kind = OP_DISC;
            3'd3:    n_cmd.kind = OP_LOAD;
            default: n_cmd.kind = OP_READ;
        endcase
    end

    assign o_full      = (r_cnt == 2'(QDEPTH));
    assign push_ok     = i_push && !o_full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign take_ok     = i_cmd_take && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    // Hold queued commands
    always_ff @(posedge i_clk) begin
        if (push_ok) r_q[r_wp] <= n_cmd;
    end

    // Advance queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push_ok) r_wp <= ~r_wp;
            if (take_ok) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push_ok) - 2'(take_ok);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QDEPTH)) else $error("queue overflow");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |=> r_cnt >= 2'(QDEPTH - 1)) else $error("full dropped too fast");
    a_empty_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 && !push_ok) |=> !o_cmd_valid) else $error("phantom command");
endmodule

### rtl/tspe_back.sv
// Back end: synapse memories, read-modify-write, sweeps and the result register.
module tspe_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    input  tspe_pkg::t_cmd        i_cmd,
    output logic                  o_cmd_take,
    input  logic signed [23:0]    i_ltp,
    input  logic signed [23:0]    i_ltd,
    input  logic [tspe_pkg::CNT_W-1:0] i_rows,
    input  logic [tspe_pkg::CNT_W-1:0] i_cols,
    output logic                  o_empty,
    input  logic                  i_pop,
    output logic [1:0]            o_status,
    output logic signed [1:0]     o_weight_out,
    output logic signed [23:0]    o_accumulator_out,
    output logic [12:0]           o_change_count,
    output logic [31:0]           o_ltp_events,
    output logic [31:0]           o_ltd_events
);
    import tspe_pkg::*;

    localparam logic signed [ACC_WIDTH:0] AMAX = (ACC_WIDTH+1)'((1 << (ACC_WIDTH-1)) - 1);
    localparam logic signed [ACC_WIDTH:0] AMIN = -(ACC_WIDTH+1)'(1 << (ACC_WIDTH-1));

    // Synapse memories, zeroed by a clearing pass after reset
    logic signed [1:0]           m_w [CELLS];
    logic signed [ACC_WIDTH-1:0] m_a [CELLS];
    logic [ADDR_W-1:0]           r_clr;
    logic                        r_clr_on;

    t_bstate r_st, n_st;
    t_cmd    r_cmd;
    logic [ROW_W-1:0] r_i, r_ri;
    logic [COL_W-1:0] r_j, r_rj;
    logic signed [1:0]           r_rw;
    logic signed [ACC_WIDTH-1:0] r_ra;
    logic [CHG_W-1:0] r_chg;
    logic             r_hit;
    logic [31:0]      r_ltp, r_ltd;
    logic             r_full;

    logic [ADDR_W-1:0] rd_addr, wr_addr, cmd_addr;
    logic              rd_en, wr_en, fetch_last, in_use;
    logic signed [1:0]           wr_w, rw, nw;
    logic signed [ACC_WIDTH-1:0] wr_a, ra, prod_a;
    logic signed [ACC_WIDTH:0]   sum;
    logic [ACC_WIDTH-1:0]        mag;
    logic [ACC_WIDTH+16:0]       prod;
    logic [ACC_WIDTH-1:0]        pm;
    logic                        ltp_ev, ltd_ev, rows_z;

    assign cmd_addr = {r_cmd.row, r_cmd.col};
    assign rw = r_rw;
    assign ra = r_ra;
    assign rows_z = (i_rows == '0) || (i_cols == '0);
    // The entry being processed is the last one of the region in use
    assign fetch_last = ({1'b0, r_rj} == i_cols - 1'b1) && ({1'b0, r_ri} == i_rows - 1'b1);

    // Read port, registered
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rw <= m_w[rd_addr];
            r_ra <= m_a[rd_addr];
            r_ri <= rd_addr[ADDR_W-1 -: ROW_W];
            r_rj <= rd_addr[COL_W-1:0];
        end
    end

    // Write port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            m_w[wr_addr] <= wr_w;
            m_a[wr_addr] <= wr_a;
        end
    end

    // Step the clearing pass over every entry after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0; r_clr_on <= 1'b1;
        end else if (r_clr_on) begin
            r_clr <= r_clr + 1'b1;
            if (r_clr == ADDR_W'(CELLS - 1)) r_clr_on <= 1'b0;
        end
    end

    // Datapath for update and decay
    always_comb begin
        sum = (ACC_WIDTH+1)'(ra) + (ACC_WIDTH+1)'(r_cmd.delta);
        if (sum > AMAX) sum = AMAX;
        if (sum < AMIN) sum = AMIN;
        mag  = ra[ACC_WIDTH-1] ? ACC_WIDTH'(-ra) : ACC_WIDTH'(ra);
        prod = (ACC_WIDTH+17)'(mag) * (ACC_WIDTH+17)'(r_cmd.factor);
        pm   = prod[ACC_WIDTH+15:16];
        prod_a = ra[ACC_WIDTH-1] ? -$signed(pm) : $signed(pm);
    end

    // Sequencer
    always_comb begin
        n_st = r_st; rd_en = 1'b0; rd_addr = cmd_addr; wr_en = 1'b0;
        wr_addr = cmd_addr; wr_w = rw; wr_a = ra; nw = rw;
        ltp_ev = 1'b0; ltd_ev = 1'b0; o_cmd_take = 1'b0;
        in_use = 1'b0;
        unique case (r_st)
            BS_IDLE: begin
                if (i_cmd_valid && !r_full && !r_clr_on) begin
                    o_cmd_take = 1'b1;
                    n_st = (i_cmd.kind == OP_DECAY || i_cmd.kind == OP_DISC) ?
                           BS_FETCH : BS_READ;
                end
            end
            BS_READ: begin
                rd_en = 1'b1;
                n_st = BS_EXEC;
            end
            BS_EXEC: begin
                if (r_cmd.inr && r_cmd.kind == OP_UPDATE) begin
                    nw = rule_next(rw, ACC_WIDTH'(sum), i_ltp, i_ltd);
                    wr_en = 1'b1; wr_w = nw;
                    wr_a = (nw != rw) ? '0 : ACC_WIDTH'(sum);
                    ltp_ev = (nw > rw); ltd_ev = (nw < rw);
                end else if (r_cmd.inr && r_cmd.kind == OP_LOAD) begin
                    wr_en = 1'b1; wr_w = r_cmd.weight;
                end
                n_st = BS_DONE;
            end
            BS_FETCH: begin
                rd_addr = {r_i, r_j};
                if (rows_z) n_st = BS_READ;
                else begin
                    rd_en = 1'b1;
                    n_st = BS_SWEEP;
                end
            end
            BS_SWEEP: begin
                // Process the entry read last cycle while fetching the next, unless it was the last
                in_use = 1'b1;
                wr_addr = {r_ri, r_rj};
                if (r_cmd.kind == OP_DECAY) begin
                    wr_en = 1'b1; wr_a = prod_a;
                end else if (ra != '0) begin
                    nw = rule_next(rw, ra, i_ltp, i_ltd);
                    wr_en = 1'b1; wr_w = nw; wr_a = '0;
                    ltp_ev = (nw > rw); ltd_ev = (nw < rw);
                end
                if (fetch_last) n_st = BS_READ;
                else begin
                    rd_addr = {r_i, r_j};
                    rd_en = 1'b1;
                end
            end
            BS_DONE: n_st = BS_IDLE;
            default: n_st = BS_IDLE;
        endcase
        // Zero the memories while the clearing pass runs
        if (r_clr_on) begin
            wr_en = 1'b1; wr_addr = r_clr; wr_w = '0; wr_a = '0;
        end
    end

    // Sequencer registers and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= BS_IDLE; r_ltp <= '0; r_ltd <= '0; r_full <= 1'b0;
            r_i <= '0; r_j <= '0; r_chg <= '0; r_hit <= 1'b0;
        end else begin
            r_st <= n_st;
            if (ltp_ev) r_ltp <= r_ltp + 32'd1;
            if (ltd_ev) r_ltd <= r_ltd + 32'd1;
            if (i_pop && r_full) r_full <= 1'b0;
            if (o_cmd_take) begin
                r_cmd <= i_cmd; r_i <= '0; r_j <= '0; r_chg <= '0; r_hit <= 1'b0;
            end
            // Advance sweep fetch position
            if (r_st == BS_FETCH || (r_st == BS_SWEEP && !fetch_last)) begin
                if ({1'b0, r_j} == i_cols - 1'b1) begin
                    r_j <= '0; r_i <= r_i + 1'b1;
                end else r_j <= r_j + 1'b1;
            end
            if (in_use && nw != rw && r_cmd.kind == OP_DISC) begin
                r_chg <= r_chg + 1'b1;
                if ({r_ri, r_rj} == cmd_addr) r_hit <= 1'b1;
            end
            if (r_st == BS_EXEC) begin
                r_full <= 1'b1;
                if (!r_cmd.inr) begin
                    o_status <= ST_RANGE; o_weight_out <= '0; o_accumulator_out <= '0;
                end else begin
                    o_weight_out      <= wr_en ? wr_w : rw;
                    o_accumulator_out <= wr_en ? wr_a : ra;
                    if (r_cmd.kind == OP_UPDATE) o_status <= (nw != rw) ? ST_CHANGE : ST_NONE;
                    else if (r_cmd.kind == OP_LOAD)
                        o_status <= (r_cmd.weight != rw) ? ST_CHANGE : ST_NONE;
                    else if (r_cmd.kind == OP_DISC)
                        o_status <= r_hit ? ST_CHANGE : ST_NONE;
                    else o_status <= ST_NONE;
                end
                o_change_count <= (r_cmd.kind == OP_DISC) ? r_chg : '0;
            end
        end
    end

    assign o_empty      = !r_full;
    assign o_ltp_events = r_ltp;
    assign o_ltd_events = r_ltd;

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_take |-> (r_st == BS_IDLE && !r_full)) else $error("take while busy");
    a_result_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == BS_EXEC) |-> !r_full) else $error("result overwritten");
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ltp_ev && ltd_ev)) else $error("two events at once");
endmodule

### rtl/ternary_synapse_plasticity_engine.sv
// Top level: configuration registers, command front end and synapse back end.
// Update, load and read pass from push to result through the queue, then take, read and execute.
// Sweeps read one entry per cycle over the region in use and write back each one that changes.
// The back end handles one item at a time and takes none while a result waits to be popped.
// After reset a clearing pass zeroes all 4096 entries, one per cycle, before any item.
// Reset (synchronous, active low) clears counters and queues and starts the clearing pass.
module ternary_synapse_plasticity_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         i_operation,
    input  logic [5:0]         i_pre_index,
    input  logic [5:0]         i_post_index,
    input  logic signed [15:0] i_delta,
    input  logic [16:0]        i_decay_factor,
    input  logic signed [1:0]  i_weight_value,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         o_status,
    output logic signed [1:0]  o_weight_out,
    output logic signed [23:0] o_accumulator_out,
    output logic [12:0]        o_change_count,
    output logic [31:0]        o_ltp_events,
    output logic [31:0]        o_ltd_events,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);
    import tspe_pkg::*;

    logic signed [23:0] r_ltp, r_ltd;
    logic [CNT_W-1:0]   r_pre, r_post, rows, cols;
    logic               cmd_valid, cmd_take;
    t_cmd               cmd;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ltp <= 24'sd4096; r_ltd <= -24'sd4096;
            r_pre <= CNT_W'(MAX_PRE); r_post <= CNT_W'(MAX_POST);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LTP:  r_ltp  <= i_cfg_data;
                CFG_LTD:  r_ltd  <= i_cfg_data;
                CFG_PRE:  r_pre  <= i_cfg_data[CNT_W-1:0];
                CFG_POST: r_post <= i_cfg_data[CNT_W-1:0];
                default:  r_ltp  <= r_ltp;
            endcase
        end
    end

    // Clamp counts to the array size
    assign rows = (r_pre  > CNT_W'(MAX_PRE))  ? CNT_W'(MAX_PRE)  : r_pre;
    assign cols = (r_post > CNT_W'(MAX_POST)) ? CNT_W'(MAX_POST) : r_post;

    tspe_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full),
        .i_operation, .i_pre_index, .i_post_index, .i_delta, .i_decay_factor,
        .i_weight_value, .i_rows(rows), .i_cols(cols),
        .o_cmd_valid(cmd_valid), .o_cmd(cmd), .i_cmd_take(cmd_take)
    );

    tspe_back u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .i_cmd(cmd), .o_cmd_take(cmd_take),
        .i_ltp(r_ltp), .i_ltd(r_ltd), .i_rows(rows), .i_cols(cols),
        .o_empty(empty), .i_pop(pop), .o_status, .o_weight_out, .o_accumulator_out,
        .o_change_count, .o_ltp_events, .o_ltd_events
    );
endmodule

### bench/tspe_checker.sv
// Checker for the ternary synapse engine: tracks synapse state and compares every result.
module tspe_checker
    import tspe_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               full,
    input  logic [2:0]         i_operation,
    input  logic [5:0]         i_pre_index,
    input  logic [5:0]         i_post_index,
    input  logic signed [15:0] i_delta,
    input  logic [16:0]        i_decay_factor,
    input  logic signed [1:0]  i_weight_value,
    input  logic               empty,
    input  logic               pop,
    input  logic [1:0]         o_status,
    input  logic signed [1:0]  o_weight_out,
    input  logic signed [23:0] o_accumulator_out,
    input  logic [12:0]        o_change_count,
    input  logic [31:0]        o_ltp_events,
    input  logic [31:0]        o_ltd_events,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    output int                 o_fail_count
);

    localparam longint ACC_HI = 64'sd8388607;
    localparam longint ACC_LO = -64'sd8388608;

    typedef struct {
        logic [1:0]         status;
        logic signed [1:0]  weight;
        logic [23:0]        acc;
        logic [12:0]        changes;
        logic [31:0]        ltp;
        logic [31:0]        ltd;
    } t_synapse_result;

    // Shadow of the synapse grid, counters and registers
    logic signed [1:0] weight_grid [CELLS];
    longint            acc_grid    [CELLS];
    logic [31:0]       ltp_total;
    logic [31:0]       ltd_total;
    longint            ltp_level;
    longint            ltd_level;
    logic [6:0]        row_limit;
    logic [6:0]        col_limit;

    t_synapse_result pending_results [$];

    // Move a weight by the threshold rules and count the transition
    function automatic logic signed [1:0] next_weight(logic signed [1:0] cur, longint acc);
        if (cur == 2'sd0) begin
            if (acc >= ltp_level) begin
                ltp_total++;
                return 2'sd1;
            end
            if (acc <= ltd_level) begin
                ltd_total++;
                return -2'sd1;
            end
        end else if (cur == 2'sd1) begin
            if (acc <= ltd_level) begin
                ltd_total++;
                return 2'sd0;
            end
        end else begin
            if (acc >= ltp_level) begin
                ltp_total++;
                return 2'sd0;
            end
        end
        return cur;
    endfunction

    // Apply one item to the shadow state and return the result it causes
    function automatic t_synapse_result apply_item(
        logic [2:0] op, logic [5:0] row, logic [5:0] col,
        logic signed [15:0] delta, logic [16:0] factor, logic signed [1:0] wval
    );
        t_synapse_result res;
        int     rows;
        int     cols;
        bit     in_range;
        int     addr;
        int     k;
        int     changes;
        longint sum;
        longint mag;
        logic signed [1:0] cur;
        logic signed [1:0] nw;
        rows     = (row_limit > MAX_PRE) ? MAX_PRE : int'(row_limit);
        cols     = (col_limit > MAX_POST) ? MAX_POST : int'(col_limit);
        in_range = (int'(row) < rows) && (int'(col) < cols);
        addr     = in_range ? int'(row) * MAX_POST + int'(col) : 0;
        changes  = 0;
        res.status = ST_NONE;
        if (op == OP_DECAY || op == OP_DISC) begin
            if (factor > 17'd65536) factor = 17'd65536;
            for (int i = 0; i < rows; i++) begin
                for (int j = 0; j < cols; j++) begin
                    k = i * MAX_POST + j;
                    if (op == OP_DECAY) begin
                        // scale magnitude, truncate toward zero
                        mag = (acc_grid[k] < 0) ? -acc_grid[k] : acc_grid[k];
                        mag = (mag * longint'(factor)) >>> 16;
                        acc_grid[k] = (acc_grid[k] < 0) ? -mag : mag;
                    end else if (acc_grid[k] != 0) begin
                        cur = weight_grid[k];
                        nw  = next_weight(cur, acc_grid[k]);
                        if (nw != cur) begin
                            weight_grid[k] = nw;
                            changes++;
                            if (in_range && k == addr) res.status = ST_CHANGE;
                        end
                        acc_grid[k] = 0;
                    end
                end
            end
        end else if (in_range && op == OP_UPDATE) begin
            sum = acc_grid[addr] + longint'(delta);
            if (sum > ACC_HI) sum = ACC_HI;
            if (sum < ACC_LO) sum = ACC_LO;
            cur = weight_grid[addr];
            nw  = next_weight(cur, sum);
            if (nw != cur) begin
                weight_grid[addr] = nw;
                sum = 0;
                res.status = ST_CHANGE;
            end
            acc_grid[addr] = sum;
        end else if (in_range && op == OP_LOAD) begin
            nw = (wval == -2'sd2) ? -2'sd1 : wval;
            if (nw != weight_grid[addr]) res.status = ST_CHANGE;
            weight_grid[addr] = nw;
        end
        if (!in_range) begin
            res.status = ST_RANGE;
            res.weight = 2'sd0;
            res.acc    = '0;
        end else begin
            res.weight = weight_grid[addr];
            res.acc    = acc_grid[addr][23:0];
        end
        res.changes = changes[12:0];
        res.ltp     = ltp_total;
        res.ltd     = ltd_total;
        return res;
    endfunction

    // Track registers, predict accepted items, compare delivered results
    always @(posedge i_clk) begin
        t_synapse_result exp_res;
        if (!i_rst_n) begin
            for (int k = 0; k < CELLS; k++) begin
                weight_grid[k] = 2'sd0;
                acc_grid[k]    = 0;
            end
            ltp_total = '0;
            ltd_total = '0;
            ltp_level = 4096;
            ltd_level = -4096;
            row_limit = 7'd64;
            col_limit = 7'd64;
            pending_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LTP:  ltp_level = longint'($signed(i_cfg_data));
                    CFG_LTD:  ltd_level = longint'($signed(i_cfg_data));
                    CFG_PRE:  row_limit = i_cfg_data[6:0];
                    CFG_POST: col_limit = i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (pop && !empty) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result with nothing pending: status %0d weight %0d acc %0d",
                             $time, o_status, o_weight_out, o_accumulator_out);
                    o_fail_count++;
                end else begin
                    exp_res = pending_results.pop_front();
                    if (o_status !== exp_res.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_res.status, o_status);
                        o_fail_count++;
                    end
                    if (o_weight_out !== exp_res.weight) begin
                        $display("%0t: weight expected %0d actual %0d",
                                 $time, exp_res.weight, o_weight_out);
                        o_fail_count++;
                    end
                    if (o_accumulator_out !== exp_res.acc) begin
                        $display("%0t: accumulator expected %0d actual %0d", $time,
                                 $signed(exp_res.acc), o_accumulator_out);
                        o_fail_count++;
                    end
                    if (o_change_count !== exp_res.changes) begin
                        $display("%0t: change count expected %0d actual %0d",
                                 $time, exp_res.changes, o_change_count);
                        o_fail_count++;
                    end
                    if (o_ltp_events !== exp_res.ltp) begin
                        $display("%0t: ltp events expected %0d actual %0d",
                                 $time, exp_res.ltp, o_ltp_events);
                        o_fail_count++;
                    end
                    if (o_ltd_events !== exp_res.ltd) begin
                        $display("%0t: ltd events expected %0d actual %0d",
                                 $time, exp_res.ltd, o_ltd_events);
                        o_fail_count++;
                    end
                end
            end
            if (i_push && !full) begin
                pending_results.push_back(apply_item(i_operation, i_pre_index, i_post_index,
                                                     i_delta, i_decay_factor, i_weight_value));
            end
        end
    end

    // Anything still pending at the end is a failure
    function automatic int leftover_count();
        return pending_results.size();
    endfunction

endmodule

### bench/ternary_synapse_plasticity_engine_test.sv
// Stimulus, clocking and verdict for the ternary synapse plasticity engine.
module ternary_synapse_plasticity_engine_test;
    import tspe_pkg::*;

    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam int STALL_LIMIT = 40000;

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic [2:0]         i_operation;
    logic [5:0]         i_pre_index;
    logic [5:0]         i_post_index;
    logic signed [15:0] i_delta;
    logic [16:0]        i_decay_factor;
    logic signed [1:0]  i_weight_value;
    logic               empty;
    logic               pop;
    logic [1:0]         o_status;
    logic signed [1:0]  o_weight_out;
    logic signed [23:0] o_accumulator_out;
    logic [12:0]        o_change_count;
    logic [31:0]        o_ltp_events;
    logic [31:0]        o_ltd_events;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [23:0]        i_cfg_data;
    int                 fail_count;

    int  items_sent;
    int  items_done;
    bit  idle_gaps;
    bit  hold_request;
    int  idle_cycles;
    int  rows_in_use;
    int  cols_in_use;
    int  sweep_pct;
    int  push_bias;

    ternary_synapse_plasticity_engine u_dut (.*);

    tspe_checker u_checker (
        .i_clk, .i_rst_n, .i_push(push), .full, .i_operation, .i_pre_index, .i_post_index,
        .i_delta, .i_decay_factor, .i_weight_value, .empty, .pop, .o_status,
        .o_weight_out, .o_accumulator_out, .o_change_count, .o_ltp_events,
        .o_ltd_events, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Count handshakes and stop a hung run
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            items_sent  <= 0;
            items_done  <= 0;
            idle_cycles <= 0;
        end else begin
            if (push && !full) items_sent <= items_sent + 1;
            if (pop && !empty) items_done <= items_done + 1;
            if ((push && !full) || (pop && !empty) || i_cfg_we) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Drain results with random stalls and one long hold
    initial begin
        int gap;
        gap = 0;
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                gap = 300;
            end
            if (gap > 0) begin
                pop <= 1'b0;
                gap--;
            end else begin
                pop <= 1'b1;
                if (idle_gaps) gap = pick_gap();
            end
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [23:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Program all four registers; the block is idle here
    task automatic set_phase(int ltp, int ltd, int rows, int cols);
        write_reg(CFG_LTP, 24'(ltp));
        write_reg(CFG_LTD, 24'(ltd));
        write_reg(CFG_PRE, 24'(rows));
        write_reg(CFG_POST, 24'(cols));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        rows_in_use = (rows > 64) ? 64 : rows;
        cols_in_use = (cols > 64) ? 64 : cols;
    endtask

    // Offer one item and hold it until accepted, then idle a while when idle gaps are on
    task automatic send_item(logic [2:0] op, logic [5:0] row, logic [5:0] col,
                             logic [15:0] delta, logic [16:0] factor, logic [1:0] wval);
        int gap;
        @(negedge i_clk);
        push           <= 1'b1;
        i_operation    <= op;
        i_pre_index    <= row;
        i_post_index   <= col;
        i_delta        <= delta;
        i_decay_factor <= factor;
        i_weight_value <= wval;
        while (full) @(negedge i_clk);
        @(posedge i_clk);
        gap = idle_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (items_done != items_sent) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    function automatic logic [5:0] pick_index(int limit);
        if ($urandom_range(0, 9) == 0) return 6'($urandom());
        return 6'($urandom_range(0, (limit > 0) ? limit : 0));
    endfunction

    // One random item, weighted toward updates inside the region in use
    task automatic random_item();
        int          roll;
        logic [2:0]  op;
        logic [15:0] delta;
        logic [16:0] factor;
        roll = $urandom_range(0, 99);
        if (roll < sweep_pct)          op = OP_DECAY;
        else if (roll < 2 * sweep_pct) op = OP_DISC;
        else if (roll < 60)            op = OP_UPDATE;
        else if (roll < 72)            op = OP_LOAD;
        else if (roll < 92)            op = OP_READ;
        else                           op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        roll = $urandom_range(0, 9);
        if (push_bias != 0 && roll < 8)
            delta = 16'($urandom_range(20000, 32767) * push_bias);
        else if (roll < 5)
            delta = 16'($signed($urandom_range(0, 12000)) - 6000);
        else if (roll < 7)
            delta = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
        else
            delta = 16'($urandom());
        roll = $urandom_range(0, 9);
        if (roll < 6)      factor = 17'($urandom_range(40000, 65536));
        else               factor = 17'($urandom());
        send_item(op, pick_index(rows_in_use), pick_index(cols_in_use),
                  delta, factor, 2'($urandom()));
    endtask

    initial begin
        i_rst_n        = 1'b0;
        push           = 1'b0;
        i_operation    = OP_READ;
        i_pre_index    = '0;
        i_post_index   = '0;
        i_delta        = '0;
        i_decay_factor = '0;
        i_weight_value = '0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_LTP;
        i_cfg_data     = '0;
        idle_gaps      = 1'b1;
        hold_request   = 1'b0;
        rows_in_use    = 64;
        cols_in_use    = 64;
        sweep_pct      = 1;
        push_bias      = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset thresholds, full grid
        send_item(OP_READ, 6'd0, 6'd0, 16'h0000, 17'd0, 2'b00);
        send_item(OP_UPDATE, 6'd0, 6'd0, 16'h7FFF, 17'd0, 2'b00);
        send_item(OP_UPDATE, 6'd0, 6'd0, 16'h8000, 17'd0, 2'b00);
        send_item(OP_UPDATE, 6'd0, 6'd0, 16'h8000, 17'd0, 2'b00);
        send_item(OP_UPDATE, 6'd63, 6'd63, 16'd2000, 17'd0, 2'b00);
        send_item(OP_UPDATE, 6'd1, 6'd2, 16'hF000, 17'd0, 2'b00);
        send_item(OP_DECAY, 6'd63, 6'd63, 16'h0000, 17'd32768, 2'b00);
        send_item(OP_DECAY, 6'd1, 6'd2, 16'h0000, 17'h1FFFF, 2'b00);
        send_item(OP_LOAD, 6'd5, 6'd5, 16'h0000, 17'd0, 2'b10);
        send_item(OP_LOAD, 6'd5, 6'd5, 16'h0000, 17'd0, 2'b01);
        send_item(OP_LOAD, 6'd5, 6'd5, 16'h0000, 17'd0, 2'b11);
        send_item(OP_LOAD, 6'd5, 6'd5, 16'h0000, 17'd0, 2'b00);
        send_item(OP_DISC, 6'd63, 6'd63, 16'h0000, 17'd0, 2'b00);
        send_item(OP_UPDATE, 6'd3, 6'd3, 16'd1000, 17'd0, 2'b00);
        send_item(OP_DECAY, 6'd3, 6'd3, 16'h0000, 17'd0, 2'b00);
        send_item(OP_SPARE_LO, 6'd3, 6'd3, 16'h0000, 17'd0, 2'b00);
        send_item(3'd6, 6'd0, 6'd0, 16'h0000, 17'd0, 2'b00);
        send_item(OP_SPARE_HI, 6'd63, 6'd63, 16'hFFFF, 17'h1FFFF, 2'b11);
        repeat (100) random_item();
        drain();

        // Extreme thresholds on one synapse: drive the accumulator into saturation
        set_phase(8388607, -8388608, 1, 1);
        sweep_pct = 4;
        send_item(OP_UPDATE, 6'd1, 6'd0, 16'h7FFF, 17'd0, 2'b00);
        for (int n = 0; n < 250; n++) begin
            if (n % 60 == 0) push_bias = ($urandom_range(0, 1) != 0) ? 1 : -1;
            random_item();
        end
        push_bias = 0;
        drain();

        // No synapse in use, no idling
        idle_gaps = 1'b0;
        set_phase(-8388608, 8388607, 0, 5);
        repeat (50) random_item();
        drain();

        // Oversized row count; the receiver holds off while items keep coming
        idle_gaps = 1'b1;
        set_phase(2000, -3000, 127, 3);
        sweep_pct = 3;
        repeat (40) random_item();
        hold_request = 1'b1;
        repeat (110) random_item();
        drain();

        // Random thresholds and small grids; pause once until all results are in
        set_phase(int'($urandom_range(0, 20000)), -int'($urandom_range(0, 20000)),
                  int'($urandom_range(1, 8)), int'($urandom_range(1, 8)));
        sweep_pct = 5;
        repeat (100) random_item();
        drain();
        set_phase(int'($urandom_range(0, 8000)) - 4000, int'($urandom_range(0, 8000)) - 4000,
                  int'($urandom_range(1, 8)), int'($urandom_range(1, 8)));
        repeat (100) random_item();
        drain();

        // Full grid again with rare sweeps, no idling
        idle_gaps = 1'b0;
        set_phase(3000, -3000, 64, 64);
        sweep_pct = 1;
        repeat (140) random_item();
        drain();

        if (fail_count == 0 && u_checker.leftover_count() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### ternary_synapse_plasticity_engine.f
rtl/tspe_pkg.sv
rtl/tspe_front.sv
rtl/tspe_back.sv
rtl/ternary_synapse_plasticity_engine.sv
bench/tspe_checker.sv
bench/ternary_synapse_plasticity_engine_test.sv
